>>> sv/mdc_pkg.sv
// mdc_pkg: types, constants and hash helpers for the message deframer
// used by the controller, datapath and top level of message_deframer_checksum; depends on nothing

package mdc_pkg;

    localparam int COMMAND_BYTES = 12;
    localparam int CHECK_BYTES   = 4;
    localparam int CMD_MAX       = 16;
    localparam int CHK_MAX       = 32;

    localparam logic [31:0] MAGIC_RESET = 32'hF9BEB4D9;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STAT_MISMATCH = 2'd2;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    typedef enum logic [2:0] {
        PH_MAGIC, PH_COMMAND, PH_LENGTH, PH_CHECK, PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        PAD_MARK, PAD_ZERO, PAD_LEN, PAD_DONE
    } pad_t;

    typedef enum logic [2:0] {
        C_IDLE, C_POST, C_PAD, C_ROUND, C_ADD, C_ROUND2, C_CHK, C_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic take;
        logic start;
        logic start2;
        logic round;
        logic add;
        logic pad;
        logic check;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic fin;
        logic pad_done;
        logic res;
        logic last_round;
    } dp_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> sv/mdc_datapath.sv
// mdc_datapath: header capture, sha-256 round unit, padding and result registers
// depends on mdc_pkg; driven by mdc_controller commands

module mdc_datapath import mdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  dp_cmd_t      cmd,
    output dp_stat_t     stat,
    input  logic [7:0]   data_byte,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_data,
    output logic         has_byte,
    output logic [7:0]   payload_out,
    output logic         end_of_message,
    output logic [1:0]   status,
    output logic [31:0]  command_high,
    output logic [63:0]  command_low,
    output logic [31:0]  payload_length
);

    logic [31:0] magic_reg;
    phase_t      phase_reg;
    logic [4:0]  fp_reg;
    logic        full_reg;
    logic        fin_reg;
    logic        res_reg;
    pad_t        pad_reg;
    logic [2:0]  padn_reg;
    logic [5:0]  rcnt_reg;
    logic [34:0] bits_reg;

    logic [7:0]  cmd_reg [CMD_MAX];
    logic [7:0]  chk_reg [CHK_MAX];
    logic [31:0] len_reg;
    logic [31:0] left_reg;
    logic [34:0] tot_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] win_reg [16];
    logic [31:0] wv_reg [8];
    logic        stg_has_reg;
    logic [7:0]  stg_byte_reg;
    logic        stg_end_reg;
    logic [1:0]  stg_status_reg;
    logic        stg_info_reg;

    logic        has_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic [1:0]  status_reg;
    logic [31:0] chi_reg;
    logic [63:0] clo_reg;
    logic [31:0] plen_reg;

    logic        hb_en;
    logic [7:0]  hb_byte;
    logic [7:0]  pad_byte;
    logic [5:0]  pos;
    logic [31:0] hb_word;
    logic [7:0]  magic_byte;
    logic        take_last;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;
    logic        match;
    logic [31:0] digest [8];
    logic [63:0] len64;
    logic [31:0] chi_next;
    logic [63:0] clo_next;

    assign pos        = bits_reg[8:3];
    assign magic_byte = 8'(magic_reg >> {2'd3 - fp_reg[1:0], 3'b000});
    assign len64      = {29'd0, tot_reg};
    assign hb_en      = (cmd.take && phase_reg == PH_PAYLOAD) || cmd.pad;
    assign hb_byte    = cmd.pad ? pad_byte : data_byte;
    assign hb_word    = 32'(hb_byte) << {2'd3 - pos[1:0], 3'b000};
    assign take_last  = left_reg == 32'd1;

    always_comb
    begin
        unique case (pad_reg)
            PAD_MARK: pad_byte = 8'h80;
            PAD_LEN:  pad_byte = 8'(len64 >> {~padn_reg, 3'b000});
            default:  pad_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        t1 = wv_reg[7] + bsig1(wv_reg[4])
           + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
           + SHA_K[rcnt_reg] + win_reg[0];
        t2 = bsig0(wv_reg[0])
           + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
        w_new = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    end

    always_comb
    begin
        match = 1'b1;
        for (int j = 0; j < 8; j++)
        begin
            digest[j] = SHA_IV[j] + wv_reg[j];
        end
        for (int i = 0; i < CHECK_BYTES; i++)
        begin
            if (8'(digest[i / 4] >> (24 - 8 * (i % 4))) != chk_reg[i])
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        clo_next = '0;
        chi_next = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < COMMAND_BYTES)
            begin
                clo_next[8 * i +: 8] = cmd_reg[i];
            end
        end
        for (int i = 8; i < 12; i++)
        begin
            if (i < COMMAND_BYTES)
            begin
                chi_next[8 * (i - 8) +: 8] = cmd_reg[i];
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= MAGIC_RESET;
            phase_reg <= PH_MAGIC;
            fp_reg    <= '0;
            full_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            res_reg   <= 1'b0;
            pad_reg   <= PAD_MARK;
            padn_reg  <= '0;
            rcnt_reg  <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                magic_reg <= cfg_data;
            end
            if (hb_en)
            begin
                bits_reg <= bits_reg + 35'd8;
                if (pos == 6'd63)
                begin
                    full_reg <= 1'b1;
                end
            end
            if (cmd.start || cmd.start2)
            begin
                full_reg <= 1'b0;
                rcnt_reg <= '0;
            end
            if (cmd.round)
            begin
                rcnt_reg <= rcnt_reg + 6'd1;
            end
            if (cmd.pad)
            begin
                unique case (pad_reg)
                    PAD_MARK, PAD_ZERO: pad_reg <= (pos == 6'd55) ? PAD_LEN : PAD_ZERO;
                    PAD_LEN:
                    begin
                        padn_reg <= padn_reg + 3'd1;
                        if (padn_reg == 3'd7)
                        begin
                            pad_reg <= PAD_DONE;
                        end
                    end
                    default: pad_reg <= PAD_DONE;
                endcase
            end
            if (cmd.check)
            begin
                fin_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                res_reg <= 1'b0;
            end
            if (cmd.take)
            begin
                unique case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (data_byte != magic_byte)
                        begin
                            fp_reg  <= '0;
                            res_reg <= 1'b1;
                        end
                        else if (fp_reg[1:0] == 2'd3)
                        begin
                            phase_reg <= PH_COMMAND;
                            fp_reg    <= '0;
                        end
                        else
                        begin
                            fp_reg <= {3'd0, fp_reg[1:0]} + 5'd1;
                        end
                    end
                    PH_COMMAND:
                    begin
                        if (fp_reg == 5'(COMMAND_BYTES - 1))
                        begin
                            phase_reg <= PH_LENGTH;
                            fp_reg    <= '0;
                        end
                        else
                        begin
                            fp_reg <= fp_reg + 5'd1;
                        end
                    end
                    PH_LENGTH:
                    begin
                        if (fp_reg[1:0] == 2'd3)
                        begin
                            phase_reg <= PH_CHECK;
                            fp_reg    <= '0;
                        end
                        else
                        begin
                            fp_reg <= fp_reg + 5'd1;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (fp_reg == 5'(CHECK_BYTES - 1))
                        begin
                            fp_reg   <= '0;
                            bits_reg <= '0;
                            if (len_reg == 32'd0)
                            begin
                                phase_reg <= PH_MAGIC;
                                fin_reg   <= 1'b1;
                                res_reg   <= 1'b1;
                                pad_reg   <= PAD_MARK;
                                padn_reg  <= '0;
                            end
                            else
                            begin
                                phase_reg <= PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            fp_reg <= fp_reg + 5'd1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        res_reg <= 1'b1;
                        if (take_last)
                        begin
                            phase_reg <= PH_MAGIC;
                            fp_reg    <= '0;
                            fin_reg   <= 1'b1;
                            pad_reg   <= PAD_MARK;
                            padn_reg  <= '0;
                        end
                    end
                    default:
                    begin
                        phase_reg <= PH_MAGIC;
                        fp_reg    <= '0;
                    end
                endcase
            end
        end
    end

    // message window, hash state, header fields and result registers
    always_ff @(posedge clk)
    begin
        if (hb_en)
        begin
            if (pos[1:0] == 2'd0)
            begin
                win_reg[pos[5:2]] <= hb_word;
            end
            else
            begin
                win_reg[pos[5:2]] <= win_reg[pos[5:2]] | hb_word;
            end
        end
        if (cmd.start)
        begin
            wv_reg <= hash_reg;
        end
        if (cmd.start2)
        begin
            wv_reg <= SHA_IV;
            for (int j = 0; j < 8; j++)
            begin
                win_reg[j] <= hash_reg[j];
            end
            win_reg[8] <= 32'h8000_0000;
            for (int j = 9; j < 15; j++)
            begin
                win_reg[j] <= '0;
            end
            win_reg[15] <= 32'd256;
        end
        if (cmd.round)
        begin
            for (int j = 0; j < 15; j++)
            begin
                win_reg[j] <= win_reg[j + 1];
            end
            win_reg[15] <= w_new;
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
        if (cmd.add)
        begin
            for (int j = 0; j < 8; j++)
            begin
                hash_reg[j] <= hash_reg[j] + wv_reg[j];
            end
        end
        if (cmd.check)
        begin
            stg_status_reg <= match ? STAT_OK : STAT_MISMATCH;
        end
        if (cmd.emit)
        begin
            has_reg    <= stg_has_reg;
            byte_reg   <= stg_byte_reg;
            end_reg    <= stg_end_reg;
            status_reg <= stg_status_reg;
            chi_reg    <= stg_info_reg ? chi_next : '0;
            clo_reg    <= stg_info_reg ? clo_next : '0;
            plen_reg   <= stg_info_reg ? len_reg : '0;
        end
        if (cmd.take)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    stg_has_reg    <= 1'b0;
                    stg_byte_reg   <= '0;
                    stg_end_reg    <= 1'b1;
                    stg_status_reg <= STAT_BAD_MAGIC;
                    stg_info_reg   <= 1'b0;
                    if (data_byte == magic_byte && fp_reg[1:0] == 2'd3)
                    begin
                        for (int i = 0; i < CMD_MAX; i++)
                        begin
                            cmd_reg[i] <= '0;
                        end
                        for (int i = 0; i < CHK_MAX; i++)
                        begin
                            chk_reg[i] <= '0;
                        end
                        len_reg <= '0;
                    end
                end
                PH_COMMAND:
                begin
                    if (fp_reg < 5'(COMMAND_BYTES))
                    begin
                        cmd_reg[fp_reg[3:0]] <= data_byte;
                    end
                end
                PH_LENGTH:
                begin
                    len_reg <= len_reg | (32'(data_byte) << {fp_reg[1:0], 3'b000});
                end
                PH_CHECK:
                begin
                    chk_reg[fp_reg] <= data_byte;
                    if (fp_reg == 5'(CHECK_BYTES - 1))
                    begin
                        hash_reg       <= SHA_IV;
                        left_reg       <= len_reg;
                        tot_reg        <= '0;
                        stg_has_reg    <= 1'b0;
                        stg_byte_reg   <= '0;
                        stg_end_reg    <= 1'b1;
                        stg_status_reg <= STAT_OK;
                        stg_info_reg   <= 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    left_reg       <= left_reg - 32'd1;
                    tot_reg        <= bits_reg + 35'd8;
                    stg_has_reg    <= 1'b1;
                    stg_byte_reg   <= data_byte;
                    stg_end_reg    <= take_last;
                    stg_status_reg <= STAT_OK;
                    stg_info_reg   <= 1'b1;
                end
                default:
                begin
                    stg_info_reg <= 1'b0;
                end
            endcase
        end
    end

    assign stat.full       = full_reg;
    assign stat.fin        = fin_reg;
    assign stat.pad_done   = pad_reg == PAD_DONE;
    assign stat.res        = res_reg;
    assign stat.last_round = rcnt_reg == 6'd63;

    assign has_byte       = has_reg;
    assign payload_out    = byte_reg;
    assign end_of_message = end_reg;
    assign status         = status_reg;
    assign command_high   = chi_reg;
    assign command_low    = clo_reg;
    assign payload_length = plen_reg;

endmodule

>>> sv/mdc_controller.sv
// mdc_controller: sequencing state machine for byte intake, hashing and result hand-off
// depends on mdc_pkg; drives mdc_datapath through dp_cmd_t

module mdc_controller import mdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;

    assign in_ready  = state_reg == C_IDLE && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = C_POST;
                end
            end
            C_POST:
            begin
                priority if (stat.full)
                begin
                    state_next = C_ROUND;
                end
                else if (stat.fin && !stat.pad_done)
                begin
                    state_next = C_PAD;
                end
                else if (stat.fin)
                begin
                    state_next = C_ROUND2;
                end
                else if (stat.res)
                begin
                    state_next = C_EMIT;
                end
                else
                begin
                    state_next = C_IDLE;
                end
            end
            C_PAD:    state_next = C_POST;
            C_ROUND:  state_next = stat.last_round ? C_ADD : C_ROUND;
            C_ADD:    state_next = C_POST;
            C_ROUND2: state_next = stat.last_round ? C_CHK : C_ROUND2;
            C_CHK:    state_next = C_EMIT;
            C_EMIT:   state_next = C_IDLE;
            default:  state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            C_IDLE:   cmd.take = in_valid && in_ready;
            C_POST:
            begin
                cmd.start  = stat.full;
                cmd.start2 = !stat.full && stat.fin && stat.pad_done;
            end
            C_PAD:    cmd.pad = 1'b1;
            C_ROUND:  cmd.round = 1'b1;
            C_ADD:    cmd.add = 1'b1;
            C_ROUND2: cmd.round = 1'b1;
            C_CHK:    cmd.check = 1'b1;
            C_EMIT:   cmd.emit = 1'b1;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> sv/message_deframer_checksum.sv
// message_deframer_checksum: top level joining controller and datapath
// depends on mdc_pkg, mdc_controller, mdc_datapath

// One byte is taken per word. A header byte that gives no result passes through
// C_POST back to C_IDLE. A byte that gives a result word (a payload byte, a bad
// magic byte or the last checksum byte of an empty message) raises out_valid
// in C_EMIT, and the next byte is taken in the cycle after the word leaves.
// A byte that completes a 64-byte block also runs the single shared SHA-256
// round unit (one round per cycle). The last payload byte (or last checksum
// byte of an empty message) also runs the padding one byte at a time, one
// or two compressions of the final blocks and the 64-round second hash.
// A new byte is taken only after the previous result word has been taken
// on the output.
module message_deframer_checksum import mdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         has_byte,
    output logic [7:0]   payload_out,
    output logic         end_of_message,
    output logic [1:0]   status,
    output logic [31:0]  command_high,
    output logic [63:0]  command_low,
    output logic [31:0]  payload_length
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mdc_controller u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mdc_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .data_byte      (data_byte),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .has_byte       (has_byte),
        .payload_out    (payload_out),
        .end_of_message (end_of_message),
        .status         (status),
        .command_high   (command_high),
        .command_low    (command_low),
        .payload_length (payload_length)
    );

endmodule

>>> sv/mdc_checker.sv
// mdc_checker: port-level assertions for message_deframer_checksum
// bound to the top level; depends on nothing else

module mdc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        has_byte,
    input logic [7:0]  payload_out,
    input logic        end_of_message,
    input logic [1:0]  status
);

    a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result word is pending");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !end_of_message) |-> status == 2'd0)
        else $error("nonzero status on a mid-message word");

    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_byte) |-> payload_out == 8'd0)
        else $error("payload byte set without has_byte");

    a_one_result_per_take: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid)
        else $error("second result word without a new input word");

endmodule

bind message_deframer_checksum mdc_checker u_chk (.*);
